FILE: src/pid_pkg.sv
// Package for the PID step block: shared widths, register indexes and reset values.
// Used by the channel interfaces, the core and the checker; depends on nothing.
package pid_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF    = 8;

    // Fixed field widths.
    localparam int GAIN_W    = 16;
    localparam int PERIOD_W  = 16;
    localparam int INTEG_W   = 32;
    localparam int CFG_IDX_W = 3;

    // The period is Q0.16, so the integral increment drops 16 fraction bits.
    localparam int DT_SHIFT = PERIOD_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P       = 3'd0,
        REG_GAIN_I       = 3'd1,
        REG_GAIN_D       = 3'd2,
        REG_SETPOINT     = 3'd3,
        REG_OFFSET_BIAS  = 3'd4,
        REG_PERIOD_DT    = 3'd5,
        REG_PERIOD_RECIP = 3'd6
    } cfg_reg_t;

    localparam logic signed [GAIN_W-1:0] GAIN_RESET         = 16'sd256;
    localparam logic [PERIOD_W-1:0]      PERIOD_DT_RESET    = 16'd13107;
    localparam logic [PERIOD_W-1:0]      PERIOD_RECIP_RESET = 16'd1280;

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = 32'sh8000_0000;

endpackage

FILE: src/pid_step_if.sv
// Channel interfaces of the PID step block: sample requests, drive results, register writes.
// Depends on pid_pkg for default widths.
interface pid_sample_if #(
    parameter int WIDTH = pid_pkg::SAMPLE_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] measured_sample;

    modport source (output valid, output measured_sample, input ready);
    modport sink   (input valid, input measured_sample, output ready);
endinterface

interface pid_drive_if #(
    parameter int WIDTH = pid_pkg::SAMPLE_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] drive_value;
    logic                    drive_saturated;

    modport source (output valid, output drive_value, output drive_saturated, input ready);
    modport sink   (input valid, input drive_value, input drive_saturated, output ready);
endinterface

interface pid_cfg_if #(
    parameter int DATA_W = pid_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic [pid_pkg::CFG_IDX_W-1:0]  index;
    logic [DATA_W-1:0]              data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/pid_step_core.sv
// Top level of the discrete PID step block with its bit-serial multiply datapath.
// Depends on pid_pkg and on the channel interfaces in pid_step_if.sv.
//
// Usage: each request on the sample channel carries one measured value in signed
// Q8.8. The block answers each request with exactly one request on the drive
// channel, carrying the saturated drive value and a flag that is set when the
// error, the integral, the derivative or the drive itself was clipped.
// Register writes on the cfg channel are always accepted (ready is tied high);
// they are meant to arrive only while no sample is being worked on.
//
// Operation: one sample at a time. The five products of a step
// (error times period, error difference times reciprocal, and the three gain
// terms) run through a single shift-and-add multiplier that retires one bit of
// the 17-bit multiplier operand per cycle. A step forms the error in ST_ERR, runs
// each product through ST_MUL and ST_POST, and saturates the drive in ST_OUT; only
// then does the core return to ST_IDLE and accept the next sample.
//
// Reset puts the gains at 1.0, setpoint and bias at 0, the period at 0.2 and its
// reciprocal at 5.0, and clears the stored error and the integral. The result
// sits in an output register; a new sample is taken while it waits. If the
// receiver still holds off when the next result is ready, the core waits.
module pid_step_core #(
    parameter int SAMPLE_WIDTH = pid_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = pid_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    pid_sample_if.sink   sample,
    pid_drive_if.source  drive,
    pid_cfg_if.sink      cfg
);

    localparam int SW     = SAMPLE_WIDTH;
    // Multiplier operand: 16-bit gains sign-extended, 16-bit periods zero-extended.
    localparam int MB     = pid_pkg::PERIOD_W + 1;
    localparam int CNT_W  = $clog2(MB);
    // Multiplicand must hold the error difference and the 32-bit terms.
    localparam int MW     = (SW + 1 > pid_pkg::INTEG_W) ? SW + 1 : pid_pkg::INTEG_W;
    localparam int HW     = MW + 1;
    localparam int PW     = HW + MB;
    localparam int AW     = PW + 2;
    localparam int IW     = MW + 2;

    localparam logic signed [IW-1:0] IS_MAX = IW'(pid_pkg::INTEG_MAX);
    localparam logic signed [IW-1:0] IS_MIN = IW'(pid_pkg::INTEG_MIN);
    localparam logic signed [PW-1:0] DV_MAX = PW'(pid_pkg::INTEG_MAX);
    localparam logic signed [PW-1:0] DV_MIN = PW'(pid_pkg::INTEG_MIN);
    localparam logic signed [AW:0]   DR_MAX = {{(AW + 2 - SW){1'b0}}, {(SW - 1){1'b1}}};
    localparam logic signed [AW:0]   DR_MIN = ~DR_MAX;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL,
        ST_POST,
        ST_OUT
    } state_t;

    // Which product the multiplier is working on.
    typedef enum logic [2:0] {
        OP_INCR,
        OP_DERIV,
        OP_PROP,
        OP_INTEG,
        OP_DTERM
    } op_t;

    // Control and state registers.
    state_t                              state_reg, state_next;
    op_t                                 op_reg, op_next;
    logic [CNT_W-1:0]                    cnt_reg, cnt_next;
    logic                                sat_reg, sat_next;
    logic                                out_valid_reg, out_valid_next;
    logic signed [SW-1:0]                last_err_reg, last_err_next;
    logic signed [pid_pkg::INTEG_W-1:0]  integ_reg, integ_next;

    // Configuration registers.
    logic signed [pid_pkg::GAIN_W-1:0]   gain_p_reg, gain_p_next;
    logic signed [pid_pkg::GAIN_W-1:0]   gain_i_reg, gain_i_next;
    logic signed [pid_pkg::GAIN_W-1:0]   gain_d_reg, gain_d_next;
    logic signed [SW-1:0]                setpoint_reg, setpoint_next;
    logic signed [SW-1:0]                bias_reg, bias_next;
    logic [pid_pkg::PERIOD_W-1:0]        dt_reg, dt_next;
    logic [pid_pkg::PERIOD_W-1:0]        recip_reg, recip_next;

    // Datapath registers.
    logic signed [SW-1:0]                sample_reg, sample_next;
    logic signed [SW-1:0]                err_reg, err_next;
    logic signed [pid_pkg::INTEG_W-1:0]  deriv_reg, deriv_next;
    logic signed [AW-1:0]                acc_reg, acc_next;
    logic signed [MW-1:0]                mcand_reg, mcand_next;
    logic signed [HW-1:0]                hi_reg, hi_next;
    logic [MB-1:0]                       lo_reg, lo_next;
    logic signed [SW-1:0]                out_value_reg, out_value_next;
    logic                                out_sat_reg, out_sat_next;

    // Combinational terms.
    logic                                step_last;
    logic signed [HW:0]                  addend;
    logic signed [HW:0]                  step_sum;
    logic signed [PW-1:0]                product;
    logic signed [SW:0]                  err_diff;
    logic                                err_ovf;
    logic signed [SW-1:0]                err_sat;
    logic signed [SW:0]                  err_delta;
    logic signed [IW-1:0]                integ_sum;
    logic signed [pid_pkg::INTEG_W-1:0]  integ_clip;
    logic                                integ_ovf;
    logic signed [PW-1:0]                deriv_full;
    logic signed [pid_pkg::INTEG_W-1:0]  deriv_clip;
    logic                                deriv_ovf;
    logic signed [AW:0]                  drive_sum;
    logic signed [SW-1:0]                drive_clip;
    logic                                drive_ovf;
    logic                                out_free;

    assign sample.ready          = (state_reg == ST_IDLE);
    assign cfg.ready             = 1'b1;
    assign drive.valid           = out_valid_reg;
    assign drive.drive_value     = out_value_reg;
    assign drive.drive_saturated = out_sat_reg;

    // One multiplier bit per cycle: add (or, for the sign bit, subtract) the
    // multiplicand into the upper half and shift the pair right by one.
    assign step_last = (cnt_reg == CNT_W'(MB - 1));
    always_comb
    begin
        addend = '0;
        if (lo_reg[0])
        begin
            if (step_last)
            begin
                addend = -((HW + 1)'(mcand_reg));
            end
            else
            begin
                addend = (HW + 1)'(mcand_reg);
            end
        end
    end
    assign step_sum = (HW + 1)'(hi_reg) + addend;
    assign product  = {hi_reg, lo_reg};

    // Error, saturated to the sample width.
    assign err_diff = (SW + 1)'(setpoint_reg) - (SW + 1)'(sample_reg);
    assign err_ovf  = err_diff[SW] != err_diff[SW-1];
    assign err_sat  = err_ovf ? {err_diff[SW], {(SW - 1){~err_diff[SW]}}} : err_diff[SW-1:0];
    assign err_delta = (SW + 1)'(err_reg) - (SW + 1)'(last_err_reg);

    // Integral update with the increment floor(error * dt / 2^16).
    assign integ_sum = IW'(integ_reg) + IW'(product >>> pid_pkg::DT_SHIFT);
    always_comb
    begin
        integ_ovf = 1'b1;
        if (integ_sum > IS_MAX)
        begin
            integ_clip = pid_pkg::INTEG_MAX;
        end
        else if (integ_sum < IS_MIN)
        begin
            integ_clip = pid_pkg::INTEG_MIN;
        end
        else
        begin
            integ_clip = integ_sum[pid_pkg::INTEG_W-1:0];
            integ_ovf  = 1'b0;
        end
    end

    // Derivative, rescaled and clipped to 32 bits.
    assign deriv_full = product >>> FRAC_BITS;
    always_comb
    begin
        deriv_ovf = 1'b1;
        if (deriv_full > DV_MAX)
        begin
            deriv_clip = pid_pkg::INTEG_MAX;
        end
        else if (deriv_full < DV_MIN)
        begin
            deriv_clip = pid_pkg::INTEG_MIN;
        end
        else
        begin
            deriv_clip = deriv_full[pid_pkg::INTEG_W-1:0];
            deriv_ovf  = 1'b0;
        end
    end

    // Drive: rescaled accumulator plus bias, clipped to the sample width.
    assign drive_sum = (AW + 1)'(acc_reg >>> FRAC_BITS) + (AW + 1)'(bias_reg);
    always_comb
    begin
        drive_ovf = 1'b1;
        if (drive_sum > DR_MAX)
        begin
            drive_clip = DR_MAX[SW-1:0];
        end
        else if (drive_sum < DR_MIN)
        begin
            drive_clip = DR_MIN[SW-1:0];
        end
        else
        begin
            drive_clip = drive_sum[SW-1:0];
            drive_ovf  = 1'b0;
        end
    end

    assign out_free = ~out_valid_reg | drive.ready;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cnt_next       = cnt_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg & ~drive.ready;
        last_err_next  = last_err_reg;
        integ_next     = integ_reg;
        gain_p_next    = gain_p_reg;
        gain_i_next    = gain_i_reg;
        gain_d_next    = gain_d_reg;
        setpoint_next  = setpoint_reg;
        bias_next      = bias_reg;
        dt_next        = dt_reg;
        recip_next     = recip_reg;
        sample_next    = sample_reg;
        err_next       = err_reg;
        deriv_next     = deriv_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        out_value_next = out_value_reg;
        out_sat_next   = out_sat_reg;

        if (cfg.valid)
        begin
            unique case (cfg.index)
                pid_pkg::REG_GAIN_P:       gain_p_next   = cfg.data[pid_pkg::GAIN_W-1:0];
                pid_pkg::REG_GAIN_I:       gain_i_next   = cfg.data[pid_pkg::GAIN_W-1:0];
                pid_pkg::REG_GAIN_D:       gain_d_next   = cfg.data[pid_pkg::GAIN_W-1:0];
                pid_pkg::REG_SETPOINT:     setpoint_next = cfg.data[SW-1:0];
                pid_pkg::REG_OFFSET_BIAS:  bias_next     = cfg.data[SW-1:0];
                pid_pkg::REG_PERIOD_DT:    dt_next       = cfg.data[pid_pkg::PERIOD_W-1:0];
                pid_pkg::REG_PERIOD_RECIP: recip_next    = cfg.data[pid_pkg::PERIOD_W-1:0];
                default:                   ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid)
                begin
                    sample_next = sample.measured_sample;
                    state_next  = ST_ERR;
                end
            end
            ST_ERR:
            begin
                err_next   = err_sat;
                sat_next   = err_ovf;
                mcand_next = MW'(err_sat);
                lo_next    = {1'b0, dt_reg};
                hi_next    = '0;
                cnt_next   = '0;
                op_next    = OP_INCR;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                hi_next  = step_sum[HW:1];
                lo_next  = {step_sum[0], lo_reg[MB-1:1]};
                cnt_next = cnt_reg + CNT_W'(1);
                if (step_last)
                begin
                    state_next = ST_POST;
                end
            end
            ST_POST:
            begin
                // Default: start the next product.
                hi_next    = '0;
                cnt_next   = '0;
                state_next = ST_MUL;
                unique case (op_reg)
                    OP_INCR:
                    begin
                        integ_next = integ_clip;
                        sat_next   = sat_reg | integ_ovf;
                        mcand_next = MW'(err_delta);
                        lo_next    = {1'b0, recip_reg};
                        op_next    = OP_DERIV;
                    end
                    OP_DERIV:
                    begin
                        deriv_next = deriv_clip;
                        sat_next   = sat_reg | deriv_ovf;
                        mcand_next = MW'(err_reg);
                        lo_next    = MB'(gain_p_reg);
                        op_next    = OP_PROP;
                    end
                    OP_PROP:
                    begin
                        acc_next   = AW'(product);
                        mcand_next = MW'(integ_reg);
                        lo_next    = MB'(gain_i_reg);
                        op_next    = OP_INTEG;
                    end
                    OP_INTEG:
                    begin
                        acc_next   = acc_reg + AW'(product);
                        mcand_next = MW'(deriv_reg);
                        lo_next    = MB'(gain_d_reg);
                        op_next    = OP_DTERM;
                    end
                    OP_DTERM:
                    begin
                        acc_next   = acc_reg + AW'(product);
                        state_next = ST_OUT;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_value_next = drive_clip;
                    out_sat_next   = sat_reg | drive_ovf;
                    out_valid_next = 1'b1;
                    last_err_next  = err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, configuration and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_INCR;
            cnt_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_sat_reg   <= 1'b0;
            last_err_reg  <= '0;
            integ_reg     <= '0;
            gain_p_reg    <= pid_pkg::GAIN_RESET;
            gain_i_reg    <= pid_pkg::GAIN_RESET;
            gain_d_reg    <= pid_pkg::GAIN_RESET;
            setpoint_reg  <= '0;
            bias_reg      <= '0;
            dt_reg        <= pid_pkg::PERIOD_DT_RESET;
            recip_reg     <= pid_pkg::PERIOD_RECIP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            out_sat_reg   <= out_sat_next;
            last_err_reg  <= last_err_next;
            integ_reg     <= integ_next;
            gain_p_reg    <= gain_p_next;
            gain_i_reg    <= gain_i_next;
            gain_d_reg    <= gain_d_next;
            setpoint_reg  <= setpoint_next;
            bias_reg      <= bias_next;
            dt_reg        <= dt_next;
            recip_reg     <= recip_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        sample_reg    <= sample_next;
        err_reg       <= err_next;
        deriv_reg     <= deriv_next;
        acc_reg       <= acc_next;
        mcand_reg     <= mcand_next;
        hi_reg        <= hi_next;
        lo_reg        <= lo_next;
    end

endmodule

FILE: src/pid_step_chk.sv
// Port-level checker for the PID step core, attached with a bind statement.
// Depends on pid_pkg for the default sample width.
module pid_step_chk #(
    parameter int WIDTH = pid_pkg::SAMPLE_WIDTH_DEF
) (
    input logic             clk,
    input logic             rst_n,
    input logic             smp_valid,
    input logic             smp_ready,
    input logic             drv_valid,
    input logic             drv_ready,
    input logic [WIDTH-1:0] drv_value,
    input logic             drv_sat
);

    // A stalled result stays offered.
    a_drv_hold: assert property (@(posedge clk) disable iff (!rst_n)
        drv_valid && !drv_ready |=> drv_valid)
        else $error("drive request dropped while stalled");

    // A stalled result keeps its payload.
    a_drv_stable: assert property (@(posedge clk) disable iff (!rst_n)
        drv_valid && !drv_ready |=> $stable(drv_value) && $stable(drv_sat))
        else $error("drive payload changed while stalled");

    // Samples are worked on one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && smp_ready |=> !smp_ready ##1 !smp_ready)
        else $error("sample taken while the previous one is in work");

    // No result can come out right after a sample is taken.
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && smp_ready |=> !$rose(drv_valid))
        else $error("drive result appeared too early");

endmodule

bind pid_step_core pid_step_chk #(
    .WIDTH (SAMPLE_WIDTH)
) u_pid_step_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .smp_valid (sample.valid),
    .smp_ready (sample.ready),
    .drv_valid (drive.valid),
    .drv_ready (drive.ready),
    .drv_value (drive.drive_value),
    .drv_sat   (drive.drive_saturated)
);

FILE: dv/pid_step_checker.sv
`timescale 1ns / 100ps
// Checker for the PID step block: follows the sample, drive and register write channels,
// predicts each drive result and compares it. Depends on pid_pkg and the channel interfaces.
module pid_step_checker (
    input  logic   clk,
    input  logic   rst_n,
    pid_sample_if  sample,
    pid_drive_if   drive,
    pid_cfg_if     cfg,
    output int     fail_count,
    output int     pending
);
    import pid_pkg::*;

    localparam int     SW    = SAMPLE_WIDTH_DEF;
    localparam int     FB    = FRAC_BITS_DEF;
    localparam longint S_MAX = (longint'(1) << (SW - 1)) - 1;
    localparam longint S_MIN = -(longint'(1) << (SW - 1));
    localparam longint I_MAX = longint'(INTEG_MAX);
    localparam longint I_MIN = longint'(INTEG_MIN);

    typedef struct packed {
        logic signed [SW-1:0] value;
        logic                 clipped;
    } drive_word_t;

    drive_word_t drive_expect_q[$];

    // Register copies and loop state of the controller.
    logic signed [GAIN_W-1:0]  kp, ki, kd;
    logic signed [SW-1:0]      target, bias;
    logic [PERIOD_W-1:0]       dt, dt_recip;
    logic signed [SW-1:0]      prev_error;
    logic signed [INTEG_W-1:0] integ;

    function automatic longint clamp(input longint v, input longint lo, input longint hi,
                                     output bit hit);
        hit = (v > hi) || (v < lo);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // One control step. All arithmetic is exact in 64 bits and every rescale is an
    // arithmetic shift, so it rounds toward minus infinity.
    function automatic drive_word_t next_drive(input logic signed [SW-1:0] meas);
        longint      err;
        longint      incr;
        longint      deriv;
        longint      acc;
        longint      level;
        bit          hit;
        bit          clipped;
        drive_word_t res;
        err = clamp(longint'(target) - longint'(meas), S_MIN, S_MAX, hit);
        clipped = hit;
        incr = (err * longint'(dt)) >>> DT_SHIFT;
        integ = INTEG_W'(clamp(longint'(integ) + incr, I_MIN, I_MAX, hit));
        clipped |= hit;
        deriv = clamp(((err - longint'(prev_error)) * longint'(dt_recip)) >>> FB,
                      I_MIN, I_MAX, hit);
        clipped |= hit;
        acc = longint'(kp) * err + longint'(ki) * longint'(integ) + longint'(kd) * deriv;
        level = clamp((acc >>> FB) + longint'(bias), S_MIN, S_MAX, hit);
        clipped |= hit;
        prev_error = SW'(err);
        res.value = SW'(level);
        res.clipped = clipped;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        drive_word_t want;
        if (!rst_n)
        begin
            kp = GAIN_RESET;
            ki = GAIN_RESET;
            kd = GAIN_RESET;
            target = '0;
            bias = '0;
            dt = PERIOD_DT_RESET;
            dt_recip = PERIOD_RECIP_RESET;
            prev_error = '0;
            integ = '0;
            drive_expect_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (drive.valid && drive.ready)
            begin
                if (drive_expect_q.size() == 0)
                begin
                    $error("drive request with no sample outstanding: value %0d, flag %0b",
                           drive.drive_value, drive.drive_saturated);
                    fail_count++;
                end
                else
                begin
                    want = drive_expect_q.pop_front();
                    if (drive.drive_value !== want.value)
                    begin
                        $error("drive_value: expected %0d, got %0d",
                               want.value, drive.drive_value);
                        fail_count++;
                    end
                    if (drive.drive_saturated !== want.clipped)
                    begin
                        $error("drive_saturated: expected %0b, got %0b",
                               want.clipped, drive.drive_saturated);
                        fail_count++;
                    end
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_GAIN_P:       kp = cfg.data;
                    REG_GAIN_I:       ki = cfg.data;
                    REG_GAIN_D:       kd = cfg.data;
                    REG_SETPOINT:     target = cfg.data;
                    REG_OFFSET_BIAS:  bias = cfg.data;
                    REG_PERIOD_DT:    dt = cfg.data;
                    REG_PERIOD_RECIP: dt_recip = cfg.data;
                    default:          ;
                endcase
            end
            if (sample.valid && sample.ready)
                drive_expect_q.push_back(next_drive(sample.measured_sample));
            pending = drive_expect_q.size();
        end
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Top of the PID step testbench: clock, reset, sample and register stimulus, verdict.
// Depends on pid_pkg, the channel interfaces, pid_step_core and pid_step_checker.
module testbench;
    import pid_pkg::*;

    // 1839 sample requests in all: a short directed part and the rest random,
    // spread over three idling phases of six register settings each.
    localparam int RANDOM_ITEMS  = 1825;
    localparam int PHASES        = 3;
    localparam int SEGMENTS      = 6;
    // A quiet stretch this long, far beyond what the core needs to answer a request
    // even with the receiver stalling, means it has hung.
    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 100;

    // An index past the last register; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic rx_ready = 1'b0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   quiet_cycles = 0;
    int   fail_count;
    int   pending;
    logic [15:0] cur_setpoint = '0;

    pid_sample_if sample_ch ();
    pid_drive_if  drive_ch ();
    pid_cfg_if    cfg_ch ();

    assign drive_ch.ready = rx_ready;

    pid_step_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .drive  (drive_ch),
        .cfg    (cfg_ch)
    );

    pid_step_checker drive_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample_ch),
        .drive      (drive_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // The receiver holds off at random, at the rate of the current phase.
    always @(posedge clk)
        rx_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

    // Watchdog: any accepted request on any channel restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_ch.valid && sample_ch.ready) || (drive_ch.valid && drive_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one sample after a random idle gap and returns once it is accepted.
    // Valid stays high on return, so back-to-back requests never drop it for a step.
    // Ready is looked at on the falling edge, where it is settled for the next rising one.
    task automatic push_sample(input logic [15:0] value);
        bit took;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.measured_sample <= value;
        do
        begin
            @(negedge clk);
            took = sample_ch.ready;
            @(posedge clk);
        end
        while (!took);
    endtask

    // The sender stops until every expected drive result has come back, which also
    // leaves the core idle and safe for register writes.
    task automatic hold_until_drained();
        sample_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // One register write; valid is left high for a following write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        bit took;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        do
        begin
            @(negedge clk);
            took = cfg_ch.ready;
            @(posedge clk);
        end
        while (!took);
        if (idx == REG_SETPOINT)
            cur_setpoint = value;
    endtask

    // Writes all seven registers once the core is idle, and optionally a stray write to
    // the unmapped index after them.
    task automatic load_config(input logic [15:0] kp, input logic [15:0] ki,
                               input logic [15:0] kd, input logic [15:0] sp,
                               input logic [15:0] bias, input logic [15:0] dt,
                               input logic [15:0] recip, input bit with_stray);
        hold_until_drained();
        write_reg(REG_GAIN_P, kp);
        write_reg(REG_GAIN_I, ki);
        write_reg(REG_GAIN_D, kd);
        write_reg(REG_SETPOINT, sp);
        write_reg(REG_OFFSET_BIAS, bias);
        write_reg(REG_PERIOD_DT, dt);
        write_reg(REG_PERIOD_RECIP, recip);
        if (with_stray)
            write_reg(REG_UNMAPPED, 16'h5A5A);
        cfg_ch.valid <= 1'b0;
    endtask

    // Register values lean on the extremes and on small gains, so that the drive does
    // not sit in saturation all the time.
    function automatic logic [15:0] pick_reg_value();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4, 5:    return 16'($urandom_range(0, 1023)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    // Four samples in ten lie near the setpoint, where the loop does its real work, with
    // full-range values and the two extremes mixed in.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:          return 16'h8000;
            1:          return 16'h7FFF;
            2, 3, 4, 5: return cur_setpoint + 16'($urandom_range(0, 511)) - 16'd256;
            default:    return 16'($urandom);
        endcase
    endfunction

    // New random register settings, then a run of random samples. Now and then the
    // sender waits for all results before going on.
    task automatic random_segment(input int n_items);
        hold_until_drained();
        for (int r = 0; r < 8; r++)
        begin
            if ($urandom_range(0, 99) < 50)
                write_reg(CFG_IDX_W'(r), pick_reg_value());
        end
        cfg_ch.valid <= 1'b0;
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                hold_until_drained();
            push_sample(pick_sample());
        end
    endtask

    initial
    begin
        logic [15:0] corner_samples[9];
        corner_samples = '{16'h0000, 16'h0100, 16'hFF00, 16'h7FFF, 16'h8000,
                           16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA};

        sample_ch.valid <= 1'b0;
        sample_ch.measured_sample <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_GAIN_P;
        cfg_ch.data <= '0;
        tx_idle_pct = 35;
        rx_idle_pct = 67;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. First the reset settings against the sample extremes and
        // alternating bit patterns.
        foreach (corner_samples[k])
            push_sample(corner_samples[k]);

        // Both periods zero: the integral must freeze and the derivative vanish. The
        // gains, setpoint and bias sit at their extremes, so the error and the drive
        // clip. A write to the unmapped index follows and must be ignored.
        load_config(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 1'b1);
        push_sample(16'h8000);
        push_sample(16'h7FFF);
        push_sample(16'h0000);
        push_sample(16'hFFFB);

        // The opposite extremes, with both periods at their largest.
        load_config(16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b0);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'h0064);
        push_sample(16'hFF9C);

        // Back to unit gains: tiny errors of both signs, where rounding toward minus
        // infinity differs from truncation toward zero.
        load_config(16'h0100, 16'h0100, 16'h0100, 16'h0000, 16'h0000, PERIOD_DT_RESET,
                    PERIOD_RECIP_RESET, 1'b0);
        push_sample(16'hFFFD);
        push_sample(16'h0003);
        push_sample(16'hFFFF);
        push_sample(16'h0001);

        // Random part: the receiver stalls more than the sender idles, then the other
        // way round, then neither holds back.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    tx_idle_pct = 35;
                    rx_idle_pct = 67;
                end
                1:
                begin
                    tx_idle_pct = 67;
                    rx_idle_pct = 35;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int s = 0; s < SEGMENTS; s++)
                random_segment(RANDOM_ITEMS / (PHASES * SEGMENTS));
        end

        // Let the last results arrive, give the core time to show any stray request,
        // and read the counts away from the rising edge.
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
